### rtl/grc_pkg.sv
`timescale 1ns / 1ps
// Package for the grid ray caster: fixed map and arithmetic constants,
// payload structs, controller states, datapath commands and helper functions.
// No dependencies.
package grc_pkg;

    localparam int MAP_SIZE   = 8;
    localparam int CELL_SIZE  = 64;
    localparam int ANGLE_BITS = 12;

    localparam int CELL_Q     = CELL_SIZE * 64;
    localparam int CELL_SHIFT = $clog2(CELL_Q);
    localparam int MAP_Q      = MAP_SIZE * CELL_Q;
    localparam int MAP_CELLS  = MAP_SIZE * MAP_SIZE;
    localparam int ADDR_W     = $clog2(MAP_CELLS);
    localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
    localparam int TAN_SAT    = 4194304;
    localparam int DIV_W      = 35;
    localparam int SQ_W       = 50;
    localparam int SQ_STEPS   = 25;
    localparam int WALK_MAX   = MAP_SIZE + 2;
    localparam int CNT_W      = 6;

    localparam logic signed [31:0] SIN_A = 32'sd102944;
    localparam logic signed [31:0] SIN_B = 32'sd42047;
    localparam logic signed [31:0] SIN_C = 32'sd4639;

    typedef struct packed {
        logic               req_type;
        logic [5:0]         cell_index;
        logic [1:0]         cell_value;
        logic [15:0]        player_x;
        logic [15:0]        player_y;
        logic [11:0]        view_angle;
        logic signed [11:0] ray_offset;
    } req_t;

    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] end_x;
        logic [15:0] end_y;
        logic [1:0]  hit_type;
        logic        hit_horizontal_line;
        logic        left_map;
        logic [11:0] ray_angle;
    } res_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_CAPTURE,
        OP_SN0, OP_SN1, OP_SN2, OP_SN3, OP_SN4, OP_SN5,
        OP_DV_INIT, OP_DV_STEP, OP_DV_END,
        OP_WS0, OP_WS1, OP_WS2, OP_WS3, OP_WS4, OP_WS5,
        OP_STEP, OP_STORE,
        OP_DS1, OP_DS2, OP_DS3, OP_SQ_STEP, OP_SQ_END,
        OP_FN1, OP_FN2
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] arg;
    } cmd_t;

    typedef struct packed {
        logic out_of_map;
        logic cell_hit;
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SN0, ST_SN1, ST_SN2, ST_SN3, ST_SN4, ST_SN5,
        ST_DV_INIT, ST_DV_STEP, ST_DV_END,
        ST_WS0, ST_WS1, ST_WS2, ST_WS3, ST_WS4, ST_WS5,
        ST_WK_CHK, ST_WK_EVAL,
        ST_DS1, ST_DS2, ST_DS3, ST_SQ_STEP, ST_SQ_END,
        ST_FN1, ST_FN2
    } ctl_state_t;

    // Division by 65536 that truncates toward zero.
    function automatic logic signed [63:0] trunc16(input logic signed [63:0] p);
        logic signed [63:0] bias;
        bias = p[63] ? 64'sd65535 : 64'sd0;
        return (p + bias) >>> 16;
    endfunction

    function automatic logic [15:0] clamp16(input logic signed [31:0] v);
        logic [15:0] r;
        if (v < 0)
        begin
            r = 16'd0;
        end
        else if (v > 32'sd65535)
        begin
            r = 16'hFFFF;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### rtl/grc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the grid ray caster: sequences sine, division,
// walk, square root and output steps of the datapath. Depends on grc_pkg.
module grc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             req_type,
    input  grc_pkg::status_t status,
    output grc_pkg::cmd_t    cmd,
    output logic             busy
);

    grc_pkg::ctl_state_t state_reg, state_next;
    logic [1:0]               sel_reg, sel_next;
    logic [grc_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grc_pkg::ST_IDLE;
            sel_reg   <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            grc_pkg::ST_IDLE:
            begin
                if (start && req_type)
                begin
                    state_next = grc_pkg::ST_SN0;
                    sel_next   = 2'd0;
                end
            end
            grc_pkg::ST_SN0: state_next = grc_pkg::ST_SN1;
            grc_pkg::ST_SN1: state_next = grc_pkg::ST_SN2;
            grc_pkg::ST_SN2: state_next = grc_pkg::ST_SN3;
            grc_pkg::ST_SN3: state_next = grc_pkg::ST_SN4;
            grc_pkg::ST_SN4: state_next = grc_pkg::ST_SN5;
            grc_pkg::ST_SN5:
            begin
                if (sel_reg == 2'd2)
                begin
                    state_next = grc_pkg::ST_DV_INIT;
                    sel_next   = 2'd0;
                end
                else
                begin
                    state_next = grc_pkg::ST_SN0;
                    sel_next   = sel_reg + 2'd1;
                end
            end
            grc_pkg::ST_DV_INIT:
            begin
                state_next = grc_pkg::ST_DV_STEP;
                cnt_next   = '0;
            end
            grc_pkg::ST_DV_STEP:
            begin
                if (cnt_reg == grc_pkg::CNT_W'(grc_pkg::DIV_W - 1))
                begin
                    state_next = grc_pkg::ST_DV_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            grc_pkg::ST_DV_END:
            begin
                if (sel_reg == 2'd0)
                begin
                    state_next = grc_pkg::ST_DV_INIT;
                    sel_next   = 2'd1;
                end
                else
                begin
                    state_next = grc_pkg::ST_WS0;
                    sel_next   = 2'd0;
                end
            end
            grc_pkg::ST_WS0: state_next = grc_pkg::ST_WS1;
            grc_pkg::ST_WS1: state_next = grc_pkg::ST_WS2;
            grc_pkg::ST_WS2: state_next = grc_pkg::ST_WS3;
            grc_pkg::ST_WS3: state_next = grc_pkg::ST_WS4;
            grc_pkg::ST_WS4: state_next = grc_pkg::ST_WS5;
            grc_pkg::ST_WS5:
            begin
                state_next = grc_pkg::ST_WK_CHK;
                cnt_next   = '0;
            end
            grc_pkg::ST_WK_CHK, grc_pkg::ST_WK_EVAL:
            begin
                if ((state_reg == grc_pkg::ST_WK_CHK && status.out_of_map)
                    || (state_reg == grc_pkg::ST_WK_EVAL && (status.cell_hit
                    || cnt_reg == grc_pkg::CNT_W'(grc_pkg::WALK_MAX - 1))))
                begin
                    if (sel_reg[0] == 1'b0)
                    begin
                        state_next = grc_pkg::ST_WS0;
                        sel_next   = 2'd1;
                    end
                    else
                    begin
                        state_next = grc_pkg::ST_DS1;
                        sel_next   = 2'd0;
                    end
                end
                else if (state_reg == grc_pkg::ST_WK_CHK)
                begin
                    state_next = grc_pkg::ST_WK_EVAL;
                end
                else
                begin
                    state_next = grc_pkg::ST_WK_CHK;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            grc_pkg::ST_DS1: state_next = grc_pkg::ST_DS2;
            grc_pkg::ST_DS2: state_next = grc_pkg::ST_DS3;
            grc_pkg::ST_DS3:
            begin
                state_next = grc_pkg::ST_SQ_STEP;
                cnt_next   = '0;
            end
            grc_pkg::ST_SQ_STEP:
            begin
                if (cnt_reg == grc_pkg::CNT_W'(grc_pkg::SQ_STEPS - 1))
                begin
                    state_next = grc_pkg::ST_SQ_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            grc_pkg::ST_SQ_END:
            begin
                if (sel_reg[0] == 1'b0)
                begin
                    state_next = grc_pkg::ST_DS1;
                    sel_next   = 2'd1;
                end
                else
                begin
                    state_next = grc_pkg::ST_FN1;
                end
            end
            grc_pkg::ST_FN1: state_next = grc_pkg::ST_FN2;
            grc_pkg::ST_FN2: state_next = grc_pkg::ST_IDLE;
            default:         state_next = grc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op  = grc_pkg::OP_NOP;
        cmd.arg = sel_reg;
        busy    = (state_reg != grc_pkg::ST_IDLE);
        unique case (state_reg)
            grc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op = req_type ? grc_pkg::OP_CAPTURE : grc_pkg::OP_LOAD;
                end
            end
            grc_pkg::ST_SN0:     cmd.op = grc_pkg::OP_SN0;
            grc_pkg::ST_SN1:     cmd.op = grc_pkg::OP_SN1;
            grc_pkg::ST_SN2:     cmd.op = grc_pkg::OP_SN2;
            grc_pkg::ST_SN3:     cmd.op = grc_pkg::OP_SN3;
            grc_pkg::ST_SN4:     cmd.op = grc_pkg::OP_SN4;
            grc_pkg::ST_SN5:     cmd.op = grc_pkg::OP_SN5;
            grc_pkg::ST_DV_INIT: cmd.op = grc_pkg::OP_DV_INIT;
            grc_pkg::ST_DV_STEP: cmd.op = grc_pkg::OP_DV_STEP;
            grc_pkg::ST_DV_END:  cmd.op = grc_pkg::OP_DV_END;
            grc_pkg::ST_WS0:     cmd.op = grc_pkg::OP_WS0;
            grc_pkg::ST_WS1:     cmd.op = grc_pkg::OP_WS1;
            grc_pkg::ST_WS2:     cmd.op = grc_pkg::OP_WS2;
            grc_pkg::ST_WS3:     cmd.op = grc_pkg::OP_WS3;
            grc_pkg::ST_WS4:     cmd.op = grc_pkg::OP_WS4;
            grc_pkg::ST_WS5:     cmd.op = grc_pkg::OP_WS5;
            grc_pkg::ST_WK_CHK:
            begin
                if (status.out_of_map)
                begin
                    cmd.op  = grc_pkg::OP_STORE;
                    cmd.arg = {1'b0, sel_reg[0]};
                end
            end
            grc_pkg::ST_WK_EVAL:
            begin
                if (status.cell_hit)
                begin
                    cmd.op  = grc_pkg::OP_STORE;
                    cmd.arg = {1'b1, sel_reg[0]};
                end
                else if (cnt_reg == grc_pkg::CNT_W'(grc_pkg::WALK_MAX - 1))
                begin
                    cmd.op  = grc_pkg::OP_STORE;
                    cmd.arg = {1'b0, sel_reg[0]};
                end
                else
                begin
                    cmd.op = grc_pkg::OP_STEP;
                end
            end
            grc_pkg::ST_DS1:     cmd.op = grc_pkg::OP_DS1;
            grc_pkg::ST_DS2:     cmd.op = grc_pkg::OP_DS2;
            grc_pkg::ST_DS3:     cmd.op = grc_pkg::OP_DS3;
            grc_pkg::ST_SQ_STEP: cmd.op = grc_pkg::OP_SQ_STEP;
            grc_pkg::ST_SQ_END:  cmd.op = grc_pkg::OP_SQ_END;
            grc_pkg::ST_FN1:     cmd.op = grc_pkg::OP_FN1;
            grc_pkg::ST_FN2:     cmd.op = grc_pkg::OP_FN2;
            default:             cmd.op = grc_pkg::OP_NOP;
        endcase
    end

endmodule

### rtl/grc_dp.sv
`timescale 1ns / 1ps
// Datapath of the grid ray caster: map store, view limit registers, shared
// multiplier, iterative divider and square root, walk and result registers.
// Depends on grc_pkg.
module grc_dp
(
    input  logic             clk,
    input  logic             rst_n,
    input  grc_pkg::req_t    request,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    input  grc_pkg::cmd_t    cmd,
    output grc_pkg::status_t status,
    output grc_pkg::res_t    result,
    output logic             done
);

    localparam logic signed [31:0] CQ = 32'(grc_pkg::CELL_Q);

    logic [1:0] mem [grc_pkg::MAP_CELLS];

    logic [15:0] lim_x_reg, lim_y_reg;
    logic        done_reg;
    grc_pkg::res_t res_reg;

    logic [15:0] px_reg, py_reg;
    logic [11:0] ang_reg, offa_reg;
    logic signed [63:0] p_reg;
    logic [16:0] z16_reg, z2_reg;
    logic [1:0]  quad_reg;
    logic signed [17:0] s_reg, c_reg, co_reg;
    logic signed [23:0] tn_reg, ct_reg;
    logic [grc_pkg::DIV_W-1:0] dvd_reg;
    logic [17:0] dvs_reg, rem_reg;
    logic        neg_reg, zden_reg, npos_reg;
    logic signed [31:0] a_reg, b_reg, da_reg, db_reg;
    logic        clamp_reg;
    logic [1:0]  rd_reg;
    logic signed [31:0] vx_reg, vy_reg, hx_reg, hy_reg;
    logic [1:0]  vt_reg, ht_reg;
    logic        vl_reg, hl_reg;
    logic [grc_pkg::SQ_W-1:0] acc_reg, sqv_reg, sqr_reg, sqb_reg;
    logic [25:0] dv_reg, dh_reg;
    logic        hsel_reg;

    logic        h;
    logic signed [31:0] mul_a, mul_b;
    logic [11:0] ang_src;
    logic [15:0] b16;
    logic [14:0] zq;
    logic signed [31:0] t_c;
    logic signed [17:0] s_new, num, den;
    logic [17:0] num_abs, den_abs;
    logic [18:0] rem_sh;
    logic        rem_ge;
    logic [grc_pkg::DIV_W-1:0] qmag;
    logic signed [23:0] q_new;
    logic signed [31:0] pa, sa, slope, islope, lim, a_start, b_new, wx, wy, ex, ey;
    logic        face_pos;
    logic signed [31:0] idx32;
    logic [grc_pkg::ADDR_W-1:0] rd_addr;
    logic [grc_pkg::SQ_W-1:0] sq_trial;
    logic [25:0] raw;
    logic [15:0] dist_sat;

    function automatic logic signed [31:0] trunc_lo(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = grc_pkg::trunc16(p);
        return t[31:0];
    endfunction

    assign h = cmd.arg[0];

    always_comb
    begin
        pa       = h ? $signed({16'd0, py_reg}) : $signed({16'd0, px_reg});
        sa       = h ? $signed({16'd0, px_reg}) : $signed({16'd0, py_reg});
        slope    = h ? 32'(ct_reg) : 32'(tn_reg);
        islope   = h ? 32'(tn_reg) : 32'(ct_reg);
        lim      = h ? $signed({16'd0, lim_x_reg}) : $signed({16'd0, lim_y_reg});
        face_pos = h ? (ang_reg < 12'(2 * grc_pkg::QUARTER))
                     : (ang_reg < 12'(grc_pkg::QUARTER)
                        || ang_reg > 12'(3 * grc_pkg::QUARTER));
        a_start  = face_pos ? (((pa + CQ - 32'sd1) & ~(CQ - 32'sd1)) + 32'sd1)
                            : ((pa & ~(CQ - 32'sd1)) - 32'sd1);
        b_new    = sa + trunc_lo(p_reg);
        wx       = h ? b_reg : a_reg;
        wy       = h ? a_reg : b_reg;
        ex       = h ? hx_reg : vx_reg;
        ey       = h ? hy_reg : vy_reg;
        idx32    = ((32'sd1 * (grc_pkg::MAP_SIZE - 1)) - (wy >>> grc_pkg::CELL_SHIFT))
                   * grc_pkg::MAP_SIZE + (wx >>> grc_pkg::CELL_SHIFT);
        rd_addr  = idx32[grc_pkg::ADDR_W-1:0];
        status.out_of_map = (a_reg < 0) || (b_reg < 0) || (a_reg >= 32'(grc_pkg::MAP_Q))
                            || (b_reg >= 32'(grc_pkg::MAP_Q));
        status.cell_hit   = (rd_reg != 2'd0);
    end

    always_comb
    begin
        case (cmd.arg)
            2'd0:    ang_src = ang_reg;
            2'd1:    ang_src = ang_reg + 12'(grc_pkg::QUARTER);
            default: ang_src = offa_reg + 12'(grc_pkg::QUARTER);
        endcase
        b16 = {ang_src, {(16 - grc_pkg::ANGLE_BITS){1'b0}}};
        zq  = b16[14] ? (15'd16384 - {1'b0, b16[13:0]}) : {1'b0, b16[13:0]};
        case (cmd.op)
            grc_pkg::OP_SN3: t_c = grc_pkg::SIN_B - $signed(p_reg[47:16]);
            default:         t_c = grc_pkg::SIN_A - $signed(p_reg[47:16]);
        endcase
        s_new   = quad_reg[1] ? -$signed({1'b0, p_reg[32:16]}) : $signed({1'b0, p_reg[32:16]});
        num     = cmd.arg[0] ? c_reg : s_reg;
        den     = cmd.arg[0] ? s_reg : c_reg;
        num_abs = num[17] ? 18'(-num) : 18'(num);
        den_abs = den[17] ? 18'(-den) : 18'(den);
        rem_sh  = {rem_reg, dvd_reg[grc_pkg::DIV_W-1]};
        rem_ge  = (rem_sh >= {1'b0, dvs_reg});
        qmag    = (dvd_reg > grc_pkg::DIV_W'(grc_pkg::TAN_SAT))
                  ? grc_pkg::DIV_W'(grc_pkg::TAN_SAT) : dvd_reg;
        if (zden_reg)
        begin
            q_new = npos_reg ? 24'sd4194304 : -24'sd4194304;
        end
        else
        begin
            q_new = neg_reg ? -$signed(qmag[23:0]) : $signed(qmag[23:0]);
        end
        sq_trial = sqr_reg + sqb_reg;
        raw      = (dh_reg < dv_reg) ? dh_reg : dv_reg;
        if (co_reg <= 0)
        begin
            dist_sat = 16'd0;
        end
        else if (p_reg[47:16] > 32'd65535)
        begin
            dist_sat = 16'hFFFF;
        end
        else
        begin
            dist_sat = p_reg[31:16];
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            grc_pkg::OP_SN1:
            begin
                mul_a = $signed({15'd0, z16_reg});
                mul_b = $signed({15'd0, z16_reg});
            end
            grc_pkg::OP_SN2:
            begin
                mul_a = $signed({15'd0, p_reg[32:16]});
                mul_b = grc_pkg::SIN_C;
            end
            grc_pkg::OP_SN3:
            begin
                mul_a = $signed({15'd0, z2_reg});
                mul_b = t_c;
            end
            grc_pkg::OP_SN4:
            begin
                mul_a = $signed({15'd0, z16_reg});
                mul_b = t_c;
            end
            grc_pkg::OP_WS1:
            begin
                mul_a = a_reg - pa;
                mul_b = slope;
            end
            grc_pkg::OP_WS2:
            begin
                mul_a = da_reg;
                mul_b = slope;
            end
            grc_pkg::OP_WS4:
            begin
                mul_a = b_reg - sa;
                mul_b = islope;
            end
            grc_pkg::OP_DS1:
            begin
                mul_a = ex - $signed({16'd0, px_reg});
                mul_b = mul_a;
            end
            grc_pkg::OP_DS2:
            begin
                mul_a = ey - $signed({16'd0, py_reg});
                mul_b = mul_a;
            end
            grc_pkg::OP_FN1:
            begin
                mul_a = $signed({6'd0, raw});
                mul_b = 32'(co_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_x_reg <= 16'hFFFF;
            lim_y_reg <= 16'h8000;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == grc_pkg::OP_FN2);
            if (cfg_we)
            begin
                if (cfg_index)
                begin
                    lim_y_reg <= cfg_data;
                end
                else
                begin
                    lim_x_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == grc_pkg::OP_LOAD
            && 32'(request.cell_index) < 32'(grc_pkg::MAP_CELLS))
        begin
            mem[request.cell_index[grc_pkg::ADDR_W-1:0]] <= request.cell_value;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(mul_a) * 64'(mul_b);
        case (cmd.op)
            grc_pkg::OP_CAPTURE:
            begin
                px_reg   <= request.player_x;
                py_reg   <= request.player_y;
                ang_reg  <= request.view_angle + request.ray_offset;
                offa_reg <= request.ray_offset;
            end
            grc_pkg::OP_SN0:
            begin
                z16_reg  <= {zq, 2'b00};
                quad_reg <= b16[15:14];
            end
            grc_pkg::OP_SN2: z2_reg <= p_reg[32:16];
            grc_pkg::OP_SN5:
            begin
                case (cmd.arg)
                    2'd0:    s_reg  <= s_new;
                    2'd1:    c_reg  <= s_new;
                    default: co_reg <= s_new;
                endcase
            end
            grc_pkg::OP_DV_INIT:
            begin
                dvd_reg  <= grc_pkg::DIV_W'({num_abs, 16'd0});
                dvs_reg  <= den_abs;
                rem_reg  <= '0;
                neg_reg  <= num[17] ^ den[17];
                zden_reg <= (den == 0);
                npos_reg <= !num[17];
            end
            grc_pkg::OP_DV_STEP:
            begin
                rem_reg <= rem_ge ? 18'(rem_sh - {1'b0, dvs_reg}) : rem_sh[17:0];
                dvd_reg <= {dvd_reg[grc_pkg::DIV_W-2:0], rem_ge};
            end
            grc_pkg::OP_DV_END:
            begin
                if (cmd.arg[0])
                begin
                    ct_reg <= q_new;
                end
                else
                begin
                    tn_reg <= q_new;
                end
            end
            grc_pkg::OP_WS0:
            begin
                a_reg  <= a_start;
                da_reg <= face_pos ? CQ : -CQ;
            end
            grc_pkg::OP_WS2: b_reg <= b_new;
            grc_pkg::OP_WS3:
            begin
                db_reg <= trunc_lo(p_reg);
                if (b_reg > lim)
                begin
                    b_reg     <= lim;
                    clamp_reg <= 1'b1;
                end
                else if (b_reg < 0)
                begin
                    b_reg     <= '0;
                    clamp_reg <= 1'b1;
                end
                else
                begin
                    clamp_reg <= 1'b0;
                end
            end
            grc_pkg::OP_WS5:
            begin
                if (clamp_reg)
                begin
                    a_reg <= pa + trunc_lo(p_reg);
                end
            end
            grc_pkg::OP_STEP:
            begin
                a_reg <= a_reg + da_reg;
                b_reg <= b_reg + db_reg;
            end
            grc_pkg::OP_STORE:
            begin
                if (h)
                begin
                    hx_reg <= wx;
                    hy_reg <= wy;
                    ht_reg <= cmd.arg[1] ? rd_reg : 2'd0;
                    hl_reg <= !cmd.arg[1];
                end
                else
                begin
                    vx_reg <= wx;
                    vy_reg <= wy;
                    vt_reg <= cmd.arg[1] ? rd_reg : 2'd0;
                    vl_reg <= !cmd.arg[1];
                end
            end
            grc_pkg::OP_DS2: acc_reg <= p_reg[grc_pkg::SQ_W-1:0];
            grc_pkg::OP_DS3:
            begin
                sqv_reg <= acc_reg + p_reg[grc_pkg::SQ_W-1:0];
                sqr_reg <= '0;
                sqb_reg <= grc_pkg::SQ_W'(1) << (2 * (grc_pkg::SQ_STEPS - 1));
            end
            grc_pkg::OP_SQ_STEP:
            begin
                if (sqv_reg >= sq_trial)
                begin
                    sqv_reg <= sqv_reg - sq_trial;
                    sqr_reg <= (sqr_reg >> 1) + sqb_reg;
                end
                else
                begin
                    sqr_reg <= sqr_reg >> 1;
                end
                sqb_reg <= sqb_reg >> 2;
            end
            grc_pkg::OP_SQ_END:
            begin
                if (h)
                begin
                    dh_reg <= sqr_reg[25:0];
                end
                else
                begin
                    dv_reg <= sqr_reg[25:0];
                end
            end
            grc_pkg::OP_FN1: hsel_reg <= (dh_reg < dv_reg);
            grc_pkg::OP_FN2:
            begin
                res_reg.distance            <= dist_sat;
                res_reg.end_x               <= grc_pkg::clamp16(hsel_reg ? hx_reg : vx_reg);
                res_reg.end_y               <= grc_pkg::clamp16(hsel_reg ? hy_reg : vy_reg);
                res_reg.hit_type            <= hsel_reg ? ht_reg : vt_reg;
                res_reg.hit_horizontal_line <= hsel_reg;
                res_reg.left_map            <= hsel_reg ? hl_reg : vl_reg;
                res_reg.ray_angle           <= ang_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

### rtl/grid_ray_caster_top.sv
`timescale 1ns / 1ps
// Top level of the grid ray caster: joins the controller and the datapath.
// Depends on grc_pkg, grc_ctrl and grc_dp.
//
// A request is taken at a rising edge where start is high and busy is low.
// A request with req_type 0 writes one cell of the 8 x 8 map store in that
// same cycle and produces no result; busy stays low.
// A request with req_type 1 casts one ray. Busy is high while it runs, and the
// result then appears on result, marked by done, which is high for a single
// cycle. The receiver cannot stall.
// The time is set by three sine evaluations, the one-bit-per-cycle divider
// (tangent and cotangent), the setup of each walk, the map walks (a check and
// an evaluation per cell inside the map, up to ten cells, and a check alone
// for a point off the map), the squared lengths and bit-pair square root of
// each walk and the final scaling; the multiplying steps share one multiplier.
// The view limit registers are written through cfg_we, cfg_index and cfg_data
// only while the block is idle: a rule for the user, not enforced by the block.
// Reset returns the controller to idle and the view limits to their defaults.
// Map cells hold no defined value until written.
module grid_ray_caster_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  grc_pkg::req_t request,
    output logic          busy,
    output logic          done,
    output grc_pkg::res_t result,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data
);

    grc_pkg::cmd_t    cmd;
    grc_pkg::status_t status;

    grc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    grc_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .done      (done)
    );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_ray_caster_top: random and directed map loads and ray casts,
// predicted in fixed point and compared field by field.
// Depends on grc_pkg and the grid_ray_caster_top RTL.
module testbench;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_CAST = 1'b1;
    localparam logic CFG_VIEW_LIMIT_X = 1'b0;
    localparam logic CFG_VIEW_LIMIT_Y = 1'b1;
    localparam longint CELL_W = 4096;
    localparam longint MAP_W = 32768;
    localparam longint SAT_TAN = 4194304;
    localparam longint unsigned POLY_A = 102944;
    localparam longint unsigned POLY_B = 42047;
    localparam longint unsigned POLY_C = 4639;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    grc_pkg::req_t request = '0;
    logic          busy;
    logic          done;
    grc_pkg::res_t result;
    logic          cfg_we = 1'b0;
    logic          cfg_index = 1'b0;
    logic [15:0]   cfg_data = 16'd0;

    grc_pkg::req_t pending[$];
    grc_pkg::res_t expected_hits[$];
    int     n_issued = 0;
    int     n_accepted = 0;
    int     n_errors = 0;
    int     idle_pct = 0;
    logic [1:0] map_cells [0:63];
    longint limit_x = 65535;
    longint limit_y = 32768;

    grid_ray_caster_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint sine_q16(input int unsigned a);
        longint unsigned b, quad, r, z, z16, z2, t, s;
        b = (longint'(a) << 4) & 64'hFFFF;
        quad = b >> 14;
        r = b & 64'h3FFF;
        z = quad[0] ? (16384 - r) : r;
        z16 = z << 2;
        z2 = (z16 * z16) >> 16;
        t = POLY_B - ((z2 * POLY_C) >> 16);
        t = POLY_A - ((z2 * t) >> 16);
        s = (z16 * t) >> 16;
        return (quad >= 2) ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint tan_ratio(input longint num, input longint den);
        longint q;
        if (den == 0)
        begin
            return (num >= 0) ? SAT_TAN : -SAT_TAN;
        end
        q = (num * 65536) / den;
        if (q > SAT_TAN)
        begin
            q = SAT_TAN;
        end
        if (q < -SAT_TAN)
        begin
            q = -SAT_TAN;
        end
        return q;
    endfunction

    function automatic longint scale_q16(input longint a, input longint t);
        return (a * t) / 65536;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v)
        begin
            bt = bt >> 2;
        end
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic void walk_cells(input longint x0, input longint y0, input longint dx,
                                       input longint dy, output longint ex, output longint ey,
                                       output logic [1:0] kind, output logic off_map);
        longint x, y, row, col;
        x = x0;
        y = y0;
        kind = 2'd0;
        off_map = 1'b1;
        ex = x;
        ey = y;
        for (int i = 0; i < grc_pkg::MAP_SIZE + 2; i++)
        begin
            ex = x;
            ey = y;
            if (x < 0 || y < 0 || x >= MAP_W || y >= MAP_W)
            begin
                return;
            end
            col = x / CELL_W;
            row = 7 - y / CELL_W;
            if (map_cells[row * 8 + col] != 2'd0)
            begin
                kind = map_cells[row * 8 + col];
                off_map = 1'b0;
                return;
            end
            x = x + dx;
            y = y + dy;
        end
    endfunction

    function automatic logic [15:0] sat16(input longint v);
        if (v < 0)
        begin
            return 16'd0;
        end
        if (v > 65535)
        begin
            return 16'hFFFF;
        end
        return v[15:0];
    endfunction

    function automatic grc_pkg::res_t cast_ray(input grc_pkg::req_t rq);
        grc_pkg::res_t r;
        longint px, py, off, s, c, tn, ct, rx, ry, sdx, sdy, co;
        longint vx, vy, hx, hy;
        logic [1:0] vk, hk;
        logic   vl, hl, hsel;
        int unsigned ang, offa;
        longint unsigned dv, dh, raw, dist_q;
        px = rq.player_x;
        py = rq.player_y;
        off = rq.ray_offset;
        ang = (int'(rq.view_angle) + int'(off)) & 12'hFFF;
        offa = int'(off) & 12'hFFF;
        s = sine_q16(ang);
        c = sine_q16(ang + 1024);
        tn = tan_ratio(s, c);
        ct = tan_ratio(c, s);
        if (ang < 1024 || ang > 3072)
        begin
            rx = ((px + CELL_W - 1) / CELL_W) * CELL_W + 1;
            sdx = CELL_W;
        end
        else
        begin
            rx = (px / CELL_W) * CELL_W - 1;
            sdx = -CELL_W;
        end
        ry = py + scale_q16(rx - px, tn);
        sdy = scale_q16(sdx, tn);
        if (ry > limit_y)
        begin
            ry = limit_y;
            rx = px + scale_q16(ry - py, ct);
        end
        else if (ry < 0)
        begin
            ry = 0;
            rx = px + scale_q16(-py, ct);
        end
        walk_cells(rx, ry, sdx, sdy, vx, vy, vk, vl);
        if (ang < 2048)
        begin
            ry = ((py + CELL_W - 1) / CELL_W) * CELL_W + 1;
            sdy = CELL_W;
        end
        else
        begin
            ry = (py / CELL_W) * CELL_W - 1;
            sdy = -CELL_W;
        end
        rx = px + scale_q16(ry - py, ct);
        sdx = scale_q16(sdy, ct);
        if (rx > limit_x)
        begin
            rx = limit_x;
            ry = py + scale_q16(rx - px, tn);
        end
        else if (rx < 0)
        begin
            rx = 0;
            ry = py + scale_q16(-px, tn);
        end
        walk_cells(rx, ry, sdx, sdy, hx, hy, hk, hl);
        dv = root_floor(longint'((vx - px) * (vx - px)) + longint'((vy - py) * (vy - py)));
        dh = root_floor(longint'((hx - px) * (hx - px)) + longint'((hy - py) * (hy - py)));
        hsel = dh < dv;
        raw = hsel ? dh : dv;
        co = sine_q16(offa + 1024);
        dist_q = (co > 0) ? ((raw * longint'(co)) >> 16) : 0;
        if (dist_q > 65535)
        begin
            dist_q = 65535;
        end
        r.distance = dist_q[15:0];
        r.end_x = sat16(hsel ? hx : vx);
        r.end_y = sat16(hsel ? hy : vy);
        r.hit_type = hsel ? hk : vk;
        r.hit_horizontal_line = hsel;
        r.left_map = hsel ? hl : vl;
        r.ray_angle = ang[11:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic queue_req(input grc_pkg::req_t q);
        pending.insert(pending.size(), q);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && n_issued == n_accepted)
        begin
            if (pending.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                request <= pending.pop_front();
                start <= 1'b1;
                n_issued <= n_issued + 1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        grc_pkg::res_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_hits.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (result.distance !== want.distance)
                        report_mismatch("distance", result.distance, want.distance);
                    if (result.end_x !== want.end_x)
                        report_mismatch("end_x", result.end_x, want.end_x);
                    if (result.end_y !== want.end_y)
                        report_mismatch("end_y", result.end_y, want.end_y);
                    if (result.hit_type !== want.hit_type)
                        report_mismatch("hit_type", result.hit_type, want.hit_type);
                    if (result.hit_horizontal_line !== want.hit_horizontal_line)
                        report_mismatch("hit_horizontal_line", result.hit_horizontal_line,
                                        want.hit_horizontal_line);
                    if (result.left_map !== want.left_map)
                        report_mismatch("left_map", result.left_map, want.left_map);
                    if (result.ray_angle !== want.ray_angle)
                        report_mismatch("ray_angle", result.ray_angle, want.ray_angle);
                end
            end
            if (start && !busy)
            begin
                n_accepted <= n_accepted + 1;
                if (request.req_type == REQ_CAST)
                begin
                    expected_hits.insert(expected_hits.size(), cast_ray(request));
                end
                else
                begin
                    map_cells[request.cell_index] = request.cell_value;
                end
            end
        end
    end

    function automatic grc_pkg::req_t load_req(input int idx, input int val);
        grc_pkg::req_t q;
        q = '0;
        q.req_type = REQ_LOAD;
        q.cell_index = 6'(idx);
        q.cell_value = 2'(val);
        q.player_x = 16'($urandom);
        q.player_y = 16'($urandom);
        q.view_angle = 12'($urandom);
        q.ray_offset = 12'($urandom);
        return q;
    endfunction

    function automatic grc_pkg::req_t cast_req(input int x, input int y, input int a,
                                               input int o);
        grc_pkg::req_t q;
        q.req_type = REQ_CAST;
        q.cell_index = 6'($urandom);
        q.cell_value = 2'($urandom);
        q.player_x = 16'(x);
        q.player_y = 16'(y);
        q.view_angle = 12'(a);
        q.ray_offset = 12'(o);
        return q;
    endfunction

    function automatic grc_pkg::req_t random_req();
        int k;
        k = $urandom_range(99);
        if (k < 20)
        begin
            return load_req($urandom_range(63), ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
        end
        if (k < 30)
        begin
            return cast_req($urandom_range(65535), $urandom_range(65535), $urandom_range(4095),
                            $urandom_range(4095));
        end
        return cast_req($urandom_range(32767), $urandom_range(32767), $urandom_range(4095),
                        int'($urandom_range(800)) - 400);
    endfunction

    task automatic wait_drained();
        while (pending.size() != 0 || n_issued != n_accepted || expected_hits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_limit(input logic idx, input int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_VIEW_LIMIT_X)
            limit_x = val;
        else
            limit_y = val;
    endtask

    initial
    begin
        int lim [0:4][0:1] = '{'{65535, 32768}, '{0, 0}, '{65535, 65535}, '{20000, 9000},
                               '{32768, 16384}};
        int idle_modes [0:4] = '{0, 55, 16, 0, 55};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 64; i++)
        begin
            int row;
            row = i / 8;
            queue_req(load_req(i, (row == 0 || row == 7 || i % 8 == 0 || i % 8 == 7)
                                  ? $urandom_range(1, 3) : 0));
        end
        queue_req(load_req(63, 3));
        queue_req(load_req(27, 2));
        queue_req(cast_req(0, 0, 0, 0));
        queue_req(cast_req(65535, 65535, 4095, 2047));
        queue_req(cast_req(16384, 16384, 0, 0));
        queue_req(cast_req(16384, 16384, 1024, 0));
        queue_req(cast_req(16384, 16384, 2048, 0));
        queue_req(cast_req(16384, 16384, 3072, 0));
        queue_req(cast_req(16384, 16384, 512, -2048));
        queue_req(cast_req(16384, 16384, 512, 1024));
        queue_req(cast_req(8192, 20480, 100, 1500));
        queue_req(cast_req(4096, 4096, 1025, -1));
        queue_req(cast_req(32767, 100, 2500, 0));
        queue_req(cast_req(100, 32767, 700, 0));
        queue_req(cast_req(40000, 50000, 3000, 200));
        queue_req(load_req(27, 0));
        wait_drained();
        for (int p = 0; p < 5; p++)
        begin
            write_limit(CFG_VIEW_LIMIT_X, lim[p][0]);
            write_limit(CFG_VIEW_LIMIT_Y, lim[p][1]);
            idle_pct = idle_modes[p];
            for (int i = 0; i < 140; i++)
            begin
                queue_req(random_req());
            end
            wait_drained();
        end
        repeat (300) @(posedge clk);
        if (n_errors == 0 && expected_hits.size() == 0)
        begin
            $display("[grid_ray_caster_top] OK");
        end
        else
        begin
            $display("[grid_ray_caster_top] ERROR");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[grid_ray_caster_top] ERROR");
        $finish;
    end

endmodule

### grid_ray_caster_top.f
rtl/grc_pkg.sv
rtl/grc_ctrl.sv
rtl/grc_dp.sv
rtl/grid_ray_caster_top.sv
sim/testbench.sv
